// ===== src/pesdf_pkg.sv =====
`default_nettype none
package pesdf_pkg;

    // Upper three bytes of a PES start code
    localparam logic [23:0] START_PREFIX = 24'h000001;

    // Reset values of the stream id registers
    localparam logic [7:0] VIDEO_ID_RESET = 8'hE0;
    localparam logic [7:0] AUDIO_ID_RESET = 8'hC0;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_FEED_ACTIVE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_ID    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AUDIO_ID    = 2'd2;

    // Header phase codes: length bytes taken so far
    localparam logic [1:0] PHASE_LEN_HI  = 2'd0;
    localparam logic [1:0] PHASE_LEN_LO  = 2'd1;

    // Result queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] data_out;
        logic       payload_valid;
        logic       stream_is_audio;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

// ===== src/pesdf_front.sv =====
`default_nettype none
module pesdf_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pesdf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pesdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                              take,
    input  wire logic [7:0]                        data_in,
    output logic                                   res_valid,
    output pesdf_pkg::result_t                     res
);

    logic        feed_active_reg;
    logic [7:0]  video_id_reg;
    logic [7:0]  audio_id_reg;

    logic [31:0] start_code_reg, start_code_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] pkt_len_reg, pkt_len_next;
    logic [15:0] byte_cnt_reg, byte_cnt_next;

    logic        match_video;
    logic        match_audio;
    logic [15:0] len_shifted;
    logic [15:0] cnt_inc;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_active_reg <= 1'b0;
            video_id_reg    <= pesdf_pkg::VIDEO_ID_RESET;
            audio_id_reg    <= pesdf_pkg::AUDIO_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pesdf_pkg::REG_FEED_ACTIVE: feed_active_reg <= cfg_wdata[0];
                pesdf_pkg::REG_VIDEO_ID:    video_id_reg    <= cfg_wdata;
                pesdf_pkg::REG_AUDIO_ID:    audio_id_reg    <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Classify the current start code; video wins when both ids are equal
    assign match_video = (start_code_reg == {pesdf_pkg::START_PREFIX, video_id_reg});
    assign match_audio = (start_code_reg == {pesdf_pkg::START_PREFIX, audio_id_reg});
    assign len_shifted = {pkt_len_reg[7:0], data_in};
    assign cnt_inc     = byte_cnt_reg + 16'd1;

    // Advance the deframing state and form the result of this byte
    always_comb
    begin
        start_code_next = start_code_reg;
        phase_next      = phase_reg;
        pkt_len_next    = pkt_len_reg;
        byte_cnt_next   = byte_cnt_reg;
        res_valid       = 1'b0;
        res.data_out        = data_in;
        res.payload_valid   = 1'b1;
        res.stream_is_audio = !match_video;
        res.last            = 1'b0;

        if (take && feed_active_reg)
        begin
            if (!match_video && !match_audio)
            begin
                // No packet open: shift the byte into the start code
                start_code_next = {start_code_reg[23:0], data_in};
                phase_next      = pesdf_pkg::PHASE_LEN_HI;
            end
            else if (!phase_reg[1])
            begin
                // Collect the big-endian payload length
                pkt_len_next = len_shifted;
                phase_next   = phase_reg + 2'd1;
                if (phase_reg == pesdf_pkg::PHASE_LEN_LO)
                begin
                    byte_cnt_next = 16'd0;
                    if (len_shifted == 16'd0)
                    begin
                        // Empty packet: one marker result, then close
                        res_valid         = 1'b1;
                        res.data_out      = 8'd0;
                        res.payload_valid = 1'b0;
                        res.last          = 1'b1;
                        start_code_next   = 32'd0;
                        phase_next        = 2'd0;
                        pkt_len_next      = 16'd0;
                        byte_cnt_next     = 16'd0;
                    end
                end
            end
            else
            begin
                // Payload byte: pass it out, close on the final one
                res_valid     = 1'b1;
                byte_cnt_next = cnt_inc;
                if (cnt_inc == pkt_len_reg)
                begin
                    res.last        = 1'b1;
                    start_code_next = 32'd0;
                    phase_next      = 2'd0;
                    pkt_len_next    = 16'd0;
                    byte_cnt_next   = 16'd0;
                end
            end
        end
    end

    // Update state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= 32'd0;
            phase_reg      <= 2'd0;
            pkt_len_reg    <= 16'd0;
            byte_cnt_reg   <= 16'd0;
        end
        else
        begin
            start_code_reg <= start_code_next;
            phase_reg      <= phase_next;
            pkt_len_reg    <= pkt_len_next;
            byte_cnt_reg   <= byte_cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/pesdf_fifo.sv =====
`default_nettype none
module pesdf_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire pesdf_pkg::result_t wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output pesdf_pkg::result_t      rd_data,
    output logic                    empty
);

    pesdf_pkg::result_t               entry_reg [pesdf_pkg::FIFO_DEPTH];
    logic [pesdf_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pesdf_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pesdf_pkg::FIFO_AW:0]      count_reg, count_next;
    logic                             do_wr;
    logic                             do_rd;

    assign full    = (count_reg == (pesdf_pkg::FIFO_AW + 1)'(pesdf_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store results
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/pes_start_code_deframer_unit.sv =====
// PES start-code deframer. Raw program-stream bytes are pushed one per
// transaction; while feed_active is set, each byte either shifts into the
// start-code register or, once 0x000001 plus the video or audio stream id is
// seen, supplies the two length bytes and then the payload, which comes out
// one byte per result with a stream tag and last on the final byte. A zero
// length gives a single result with payload_valid low. Bytes are taken one
// per clock while the queue is not full; the front stage updates state and
// results pass through a four-entry queue, so a result appears in the cycle
// after its byte; full rises only when four results wait untaken. The user
// must write configuration through cfg_we/cfg_index/cfg_wdata while idle.
`default_nettype none
module pes_start_code_deframer_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pesdf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pesdf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        data_in,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [7:0]                             data_out,
    output logic                                   payload_valid,
    output logic                                   stream_is_audio,
    output logic                                   last
);

    logic               take;
    logic               res_valid;
    pesdf_pkg::result_t res;
    pesdf_pkg::result_t head;

    assign take = push && !full;

    pesdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .data_in   (data_in),
        .res_valid (res_valid),
        .res       (res)
    );

    pesdf_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .full    (full),
        .rd_en   (pop),
        .rd_data (head),
        .empty   (empty)
    );

    assign data_out        = head.data_out;
    assign payload_valid   = head.payload_valid;
    assign stream_is_audio = head.stream_is_audio;
    assign last            = head.last;

endmodule
`default_nettype wire

// ===== src/pesdf_checker.sv =====
`default_nettype none
module pesdf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] data_out,
    input wire logic       payload_valid,
    input wire logic       stream_is_audio,
    input wire logic       last
);

    // Queue is empty while reset is held
    assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    // No result appears without a byte taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(empty) && !$past(push && !full)) |-> empty)
        else $error("result appeared without an accepted byte");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({data_out, payload_valid,
                                                  stream_is_audio, last})))
        else $error("stalled result changed");

    // Empty-packet marker is a closing result with zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !payload_valid) |-> (last && data_out == 8'd0))
        else $error("malformed empty-packet marker");

    // Full implies results waiting
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !empty)
        else $error("full raised with no result waiting");

endmodule

bind pes_start_code_deframer_unit pesdf_checker u_pesdf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .data_out        (data_out),
    .payload_valid   (payload_valid),
    .stream_is_audio (stream_is_audio),
    .last            (last)
);
`default_nettype wire

// ===== tb/tb_pes_start_code_deframer_unit.sv =====
`default_nettype none
module tb_pes_start_code_deframer_unit;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PRINT_CAP   = 40;

    typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

    // One line of the directed script: a byte transaction or a register write
    typedef struct packed {
        row_kind_t                         kind;
        logic [pesdf_pkg::CFG_INDEX_W-1:0] idx;
        logic [7:0]                        value;
        logic                              typed;
        pesdf_pkg::result_t                res;
    } script_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [pesdf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pesdf_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                              push;
    logic                              full;
    logic [7:0]                        data_in;
    logic                              empty;
    logic                              pop;
    logic [7:0]                        data_out;
    logic                              payload_valid;
    logic                              stream_is_audio;
    logic                              last;

    // Deframer copy: configuration and packet state
    logic        feed_on;
    logic [7:0]  video_id;
    logic [7:0]  audio_id;
    logic [31:0] pes_code;
    logic [1:0]  len_taken;
    logic [15:0] pkt_len;
    logic [15:0] payload_seen;

    pesdf_pkg::result_t due_results[$];

    // Typed expectation travelling with the byte on offer
    logic               typed_on;
    pesdf_pkg::result_t typed_res;

    int send_idle_pct;
    int stall_pct;
    int hold_req;

    int err_count;
    int bytes_fed;
    int bytes_dropped;
    int results_checked;
    int packets_closed;
    int input_stalls;
    int cycle_count;

    pes_start_code_deframer_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .push            (push),
        .full            (full),
        .data_in         (data_in),
        .empty           (empty),
        .pop             (pop),
        .data_out        (data_out),
        .payload_valid   (payload_valid),
        .stream_is_audio (stream_is_audio),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("ERROR @%0d: %s", cycle_count, msg);
    endtask

    task automatic clear_packet();
        pes_code     = '0;
        len_taken    = '0;
        pkt_len      = '0;
        payload_seen = '0;
    endtask

    // Advance the deframer copy by one byte; made is set when a result is due
    task automatic deframe_byte(input logic [7:0] b, output bit made,
                                output pesdf_pkg::result_t res);
        logic is_audio;
        made = 1'b0;
        res = '0;
        is_audio = 1'b0;
        if (!feed_on)
            return;
        // Video wins when both ids are the same
        if (pes_code == {pesdf_pkg::START_PREFIX, video_id})
            is_audio = 1'b0;
        else if (pes_code == {pesdf_pkg::START_PREFIX, audio_id})
            is_audio = 1'b1;
        else
        begin
            pes_code  = {pes_code[23:0], b};
            len_taken = '0;
            return;
        end
        // Collect the big-endian length
        if (len_taken < 2)
        begin
            pkt_len   = {pkt_len[7:0], b};
            len_taken = len_taken + 2'd1;
            if (len_taken == 2)
            begin
                payload_seen = '0;
                if (pkt_len == 0)
                begin
                    made = 1'b1;
                    res.data_out        = 8'h00;
                    res.payload_valid   = 1'b0;
                    res.stream_is_audio = is_audio;
                    res.last            = 1'b1;
                    clear_packet();
                end
            end
            return;
        end
        // Pass the payload byte on
        payload_seen = payload_seen + 16'd1;
        made = 1'b1;
        res.data_out        = b;
        res.payload_valid   = 1'b1;
        res.stream_is_audio = is_audio;
        res.last            = (payload_seen == pkt_len);
        if (res.last)
            clear_packet();
    endtask

    // Watch every edge: follow writes, predict on accepted bytes, check results
    always @(posedge clk)
    begin : monitor
        bit                 made;
        pesdf_pkg::result_t res;
        pesdf_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pesdf_pkg::REG_FEED_ACTIVE: feed_on  = cfg_wdata[0];
                    pesdf_pkg::REG_VIDEO_ID:    video_id = cfg_wdata[7:0];
                    pesdf_pkg::REG_AUDIO_ID:    audio_id = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (push && full)
                input_stalls++;
            if (push && !full)
            begin
                if (feed_on)
                    bytes_fed++;
                else
                    bytes_dropped++;
                deframe_byte(data_in, made, res);
                if (typed_on)
                    due_results.push_back(typed_res);
                else if (made)
                    due_results.push_back(res);
            end
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                    report_error($sformatf(
                        "unexpected result: data %02h valid %0b audio %0b last %0b",
                        data_out, payload_valid, stream_is_audio, last));
                else
                begin
                    want = due_results.pop_front();
                    if (data_out !== want.data_out || payload_valid !== want.payload_valid ||
                        stream_is_audio !== want.stream_is_audio || last !== want.last)
                        report_error($sformatf(
                            "result %0d: got %02h/%0b/%0b/%0b, want %02h/%0b/%0b/%0b",
                            results_checked, data_out, payload_valid, stream_is_audio, last,
                            want.data_out, want.payload_valid, want.stream_is_audio,
                            want.last));
                    results_checked++;
                    if (want.last)
                        packets_closed++;
                end
            end
        end
    end

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one byte transaction and hold it until taken; entered and left at a falling edge
    task automatic offer_byte(input logic [7:0] b, input logic typed,
                              input pesdf_pkg::result_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            data_in <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        push      <= 1'b1;
        data_in   <= b;
        typed_on  <= typed;
        typed_res <= res;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        offer_byte(b, 1'b0, '0);
    endtask

    task automatic send_packet(input logic [7:0] id, input int len, input int cut);
        feed_byte(8'h00);
        feed_byte(8'h00);
        feed_byte(8'h01);
        feed_byte(id);
        feed_byte(len[15:8]);
        feed_byte(len[7:0]);
        for (int i = 0; i < cut; i++)
            feed_byte(8'($urandom_range(0, 255)));
    endtask

    // Stop offering, wait for every due result, then let the front stage settle
    task automatic drain();
        push <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pesdf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic script_row_t mk_row(row_kind_t kind,
                                           logic [pesdf_pkg::CFG_INDEX_W-1:0] idx,
                                           logic [7:0] value, logic typed,
                                           pesdf_pkg::result_t res);
        script_row_t row;
        row.kind  = kind;
        row.idx   = idx;
        row.value = value;
        row.typed = typed;
        row.res   = res;
        return row;
    endfunction

    initial
    begin : stimulus
        script_row_t script[$];
        logic [7:0]  vid;
        logic [7:0]  aud;
        int          target;
        int          pick;
        int          r;
        int          plen;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        push      = 1'b0;
        data_in   = '0;
        typed_on  = 1'b0;
        typed_res = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 0;
        feed_on  = 1'b0;
        video_id = pesdf_pkg::VIDEO_ID_RESET;
        audio_id = pesdf_pkg::AUDIO_ID_RESET;
        clear_packet();

        // Directed script; typed results are {data, valid, audio, last}
        // Feed off after reset: a video start code must be dropped, state untouched
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h01, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'hE0, 1'b0, '0));
        script.push_back(mk_row(ROW_WRITE, pesdf_pkg::REG_FEED_ACTIVE, 8'h01, 1'b0, '0));
        // Video packet of two bytes, extremes of the data byte
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h01, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'hE0, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h02, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'hFF, 1'b1,
                                {8'hFF, 1'b1, 1'b0, 1'b0}));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b1,
                                {8'h00, 1'b1, 1'b0, 1'b1}));
        // Zero-length audio packet closes with one empty marker
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h01, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'hC0, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b1,
                                {8'h00, 1'b0, 1'b1, 1'b1}));
        // Both ids equal: the packet is tagged video
        script.push_back(mk_row(ROW_WRITE, pesdf_pkg::REG_VIDEO_ID, 8'hC0, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h01, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'hC0, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h02, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h5A, 1'b0, '0));
        // Ids moved away while the packet is open: the next byte shifts in instead
        script.push_back(mk_row(ROW_WRITE, pesdf_pkg::REG_VIDEO_ID, 8'h00, 1'b0, '0));
        script.push_back(mk_row(ROW_WRITE, pesdf_pkg::REG_AUDIO_ID, 8'hFF, 1'b0, '0));
        script.push_back(mk_row(ROW_BYTE, pesdf_pkg::REG_FEED_ACTIVE, 8'h33, 1'b0, '0));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed script
        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(script[i].idx, script[i].value);
            end
            else
                offer_byte(script[i].value, script[i].typed, script[i].res);
        end

        // Random phases, each setting its ids and idling pattern
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            case (ph % 4)
                0:
                begin
                    vid = pesdf_pkg::VIDEO_ID_RESET;
                    aud = pesdf_pkg::AUDIO_ID_RESET;
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    vid = 8'($urandom_range(0, 255));
                    aud = 8'($urandom_range(0, 255));
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2:
                begin
                    vid = 8'($urandom_range(0, 255));
                    aud = vid;
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default:
                begin
                    vid = 8'hFF;
                    aud = 8'h00;
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            write_reg(pesdf_pkg::REG_VIDEO_ID, vid);
            write_reg(pesdf_pkg::REG_AUDIO_ID, aud);

            // Drop a burst of bytes with the feed off
            if (ph == 2)
            begin
                write_reg(pesdf_pkg::REG_FEED_ACTIVE, 8'h00);
                repeat (12) feed_byte(8'($urandom_range(0, 255)));
                drain();
                write_reg(pesdf_pkg::REG_FEED_ACTIVE, 8'h01);
            end

            // Hold the result side off while a long packet fills the queue
            if (ph == 0)
            begin
                hold_req = 300;
                send_packet(vid, 64, 64);
            end

            target = bytes_fed + 260;
            while (bytes_fed < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    plen = 0;
                else if (r < 80)
                    plen = $urandom_range(1, 8);
                else if (r < 97)
                    plen = $urandom_range(9, 40);
                else
                    plen = $urandom_range(256, 511);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_packet($urandom_range(0, 1) ? aud : vid, plen, plen);
                else if (pick < 80)
                    repeat ($urandom_range(1, 6)) feed_byte(8'($urandom_range(0, 255)));
                else if (pick < 88)
                begin
                    // Start code with an arbitrary id, usually a near miss
                    feed_byte(8'h00);
                    feed_byte(8'h00);
                    feed_byte(8'h01);
                    feed_byte(8'($urandom_range(0, 255)));
                end
                else
                    // Cut the packet short so later bytes land in its payload
                    send_packet($urandom_range(0, 1) ? aud : vid, plen,
                                (plen == 0) ? 0 : $urandom_range(0, plen - 1));
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (due_results.size() != 0)
            report_error($sformatf("%0d results never arrived", due_results.size()));

        $display("Fed %0d bytes (%0d more dropped with the feed off); checked %0d results,",
                 bytes_fed, bytes_dropped, results_checked);
        $display("%0d packets closed; input held back by a full queue for %0d cycles; %0d mismatches.",
                 packets_closed, input_stalls, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/pesdf_pkg.sv
src/pesdf_front.sv
src/pesdf_fifo.sv
src/pes_start_code_deframer_unit.sv
src/pesdf_checker.sv
tb/tb_pes_start_code_deframer_unit.sv
